### design/mss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the morph section size scanner.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned REF_W      = 3;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned POS_W      = 40;
  localparam int unsigned MCNT_W     = 31;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_V21    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MORPH_REF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_REF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BONE_REF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MATERIAL_REF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_REF     = 3'd5;

  localparam logic [REF_W-1:0] REF_RESET = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ST_NEG_LEN   = 3'd3;
  localparam logic [2:0] ST_V21_TYPE  = 3'd4;

  // fixed element body sizes
  localparam logic [SIZE_W-1:0] SZ_GROUP_BODY    = 7'd4;
  localparam logic [SIZE_W-1:0] SZ_VERTEX_BODY   = 7'd12;
  localparam logic [SIZE_W-1:0] SZ_UV_BODY       = 7'd16;
  localparam logic [SIZE_W-1:0] SZ_BONE_BODY     = 7'd28;
  localparam logic [SIZE_W-1:0] SZ_MATERIAL_BODY = 7'd113;
  localparam logic [SIZE_W-1:0] SZ_FLIP_BODY     = 7'd4;
  localparam logic [SIZE_W-1:0] SZ_IMPULSE_BODY  = 7'd25;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [POS_W-1:0]  consumed_bytes;
    logic [MCNT_W-1:0] morph_total;
  } out_item_t;

  typedef struct packed {
    logic             allow_v21_types;
    logic [REF_W-1:0] morph_ref_bytes;
    logic [REF_W-1:0] vertex_ref_bytes;
    logic [REF_W-1:0] bone_ref_bytes;
    logic [REF_W-1:0] material_ref_bytes;
    logic [REF_W-1:0] body_ref_bytes;
  } mss_cfg_t;

endpackage
`default_nettype wire

### design/mss_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_parser
// Per-byte parse state of the morph section; flags the end of a scan.
// ----------------------------------------------------------------------------
module mss_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire mss_pkg::in_item_t item,
  input  wire mss_pkg::mss_cfg_t cfg,
  output logic                   res_valid,
  output mss_pkg::out_item_t     res
);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_COUNT      = 4'd1;
  localparam logic [3:0] PH_NAME1_LEN  = 4'd2;
  localparam logic [3:0] PH_NAME1_BODY = 4'd3;
  localparam logic [3:0] PH_NAME2_LEN  = 4'd4;
  localparam logic [3:0] PH_NAME2_BODY = 4'd5;
  localparam logic [3:0] PH_CATEGORY   = 4'd6;
  localparam logic [3:0] PH_TYPE       = 4'd7;
  localparam logic [3:0] PH_ELEM_COUNT = 4'd8;
  localparam logic [3:0] PH_SKIP       = 4'd9;
  localparam logic [3:0] PH_DONE       = 4'd10;

  logic [3:0]                    phase_r, phase_nxt;
  logic [1:0]                    idx_r, idx_nxt;
  logic [31:0]                   word_r, word_nxt;
  logic [mss_pkg::POS_W-1:0]     skip_r, skip_nxt;
  logic [mss_pkg::MCNT_W-1:0]    mrem_r, mrem_nxt;
  logic [mss_pkg::MCNT_W-1:0]    latch_r, latch_nxt;
  logic [mss_pkg::POS_W-1:0]     pos_r, pos_nxt;

  logic [3:0]                    ph_e;
  logic [1:0]                    idx_e;
  logic [31:0]                   word_e, word_g;
  logic [mss_pkg::POS_W-1:0]     skip_e, skip_dec, pos_e;
  logic [mss_pkg::MCNT_W-1:0]    mrem_e, mrem_dec, latch_e, cnt_w;
  logic                          gdone, em_last, finished;
  logic [2:0]                    err;
  logic [mss_pkg::SIZE_W-1:0]    esize;
  logic [37:0]                   prod;

  always_comb begin
    // a first byte restarts the scan
    ph_e    = item.first_byte ? PH_COUNT : phase_r;
    idx_e   = item.first_byte ? 2'd0 : idx_r;
    word_e  = item.first_byte ? 32'd0 : word_r;
    skip_e  = item.first_byte ? '0 : skip_r;
    mrem_e  = item.first_byte ? '0 : mrem_r;
    latch_e = item.first_byte ? '0 : latch_r;
    pos_e   = item.first_byte ? '0 : pos_r;

    case (idx_e)
      2'd0:    word_g = {24'd0, item.data_byte};
      2'd1:    word_g = {word_e[31:16], item.data_byte, word_e[7:0]};
      2'd2:    word_g = {word_e[31:24], item.data_byte, word_e[15:0]};
      default: word_g = {item.data_byte, word_e[23:0]};
    endcase
    gdone = (idx_e == 2'd3);
    cnt_w = word_g[31] ? '0 : word_g[30:0];

    skip_dec = (skip_e != '0) ? skip_e - 40'd1 : skip_e;
    mrem_dec = (mrem_e != '0) ? mrem_e - 31'd1 : mrem_e;
    em_last  = (mrem_dec == '0);
    prod     = {7'd0, cnt_w} * {31'd0, skip_e[mss_pkg::SIZE_W-1:0]};

    err   = mss_pkg::ST_OK;
    esize = '0;
    case (item.data_byte) inside
      8'd0:          esize = {4'd0, cfg.morph_ref_bytes} + mss_pkg::SZ_GROUP_BODY;
      8'd1:          esize = {4'd0, cfg.vertex_ref_bytes} + mss_pkg::SZ_VERTEX_BODY;
      8'd2:          esize = {4'd0, cfg.bone_ref_bytes} + mss_pkg::SZ_BONE_BODY;
      [8'd3:8'd7]:   esize = {4'd0, cfg.vertex_ref_bytes} + mss_pkg::SZ_UV_BODY;
      8'd8:          esize = {4'd0, cfg.material_ref_bytes} + mss_pkg::SZ_MATERIAL_BODY;
      8'd9: begin
        if (cfg.allow_v21_types) esize = {4'd0, cfg.morph_ref_bytes} + mss_pkg::SZ_FLIP_BODY;
      end
      8'd10: begin
        if (cfg.allow_v21_types) esize = {4'd0, cfg.body_ref_bytes} + mss_pkg::SZ_IMPULSE_BODY;
      end
      default:       esize = '0;
    endcase

    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    word_nxt  = word_r;
    skip_nxt  = skip_r;
    mrem_nxt  = mrem_r;
    latch_nxt = latch_r;
    pos_nxt   = pos_r;
    finished  = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (accept && ph_e != PH_IDLE && ph_e < PH_DONE) begin
      phase_nxt = ph_e;
      idx_nxt   = idx_e;
      word_nxt  = word_e;
      skip_nxt  = skip_e;
      mrem_nxt  = mrem_e;
      latch_nxt = latch_e;
      pos_nxt   = (pos_e == '1) ? pos_e : pos_e + 40'd1;

      case (ph_e)
        PH_COUNT: begin
          word_nxt = word_g;
          idx_nxt  = idx_e + 2'd1;
          if (gdone) begin
            latch_nxt = cnt_w;
            mrem_nxt  = cnt_w;
            if (cnt_w == '0) finished = 1'b1;
            else phase_nxt = PH_NAME1_LEN;
          end
        end
        PH_NAME1_LEN, PH_NAME2_LEN: begin
          word_nxt = word_g;
          idx_nxt  = idx_e + 2'd1;
          if (gdone) begin
            if (word_g[31]) begin
              err = mss_pkg::ST_NEG_LEN;
            end else if (word_g == 32'd0) begin
              phase_nxt = ph_e + 4'd2;
            end else begin
              skip_nxt  = {8'd0, word_g};
              phase_nxt = ph_e + 4'd1;
            end
          end
        end
        PH_NAME1_BODY, PH_NAME2_BODY: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) phase_nxt = ph_e + 4'd1;
        end
        PH_CATEGORY: begin
          phase_nxt = PH_TYPE;
        end
        PH_TYPE: begin
          skip_nxt = {33'd0, esize};
          if (item.data_byte > 8'd10) begin
            err = mss_pkg::ST_BAD_TYPE;
          end else if (item.data_byte > 8'd8 && !cfg.allow_v21_types) begin
            err = mss_pkg::ST_V21_TYPE;
          end else begin
            phase_nxt = PH_ELEM_COUNT;
            idx_nxt   = 2'd0;
          end
        end
        PH_ELEM_COUNT: begin
          word_nxt = word_g;
          idx_nxt  = idx_e + 2'd1;
          if (gdone) begin
            if (prod == '0) begin
              skip_nxt = '0;
              mrem_nxt = mrem_dec;
              if (em_last) begin
                finished = 1'b1;
              end else begin
                phase_nxt = PH_NAME1_LEN;
                idx_nxt   = 2'd0;
              end
            end else begin
              skip_nxt  = {2'd0, prod};
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            mrem_nxt = mrem_dec;
            if (em_last) begin
              finished = 1'b1;
            end else begin
              phase_nxt = PH_NAME1_LEN;
              idx_nxt   = 2'd0;
            end
          end
        end
        default: begin
          phase_nxt = ph_e;
        end
      endcase

      if (finished || err != mss_pkg::ST_OK || item.last_byte) begin
        res_valid          = 1'b1;
        phase_nxt          = PH_DONE;
        res.status         = finished ? mss_pkg::ST_OK :
                             (err != mss_pkg::ST_OK) ? err : mss_pkg::ST_TRUNC;
        res.consumed_bytes = pos_nxt;
        res.morph_total    = latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      idx_r   <= '0;
      word_r  <= '0;
      skip_r  <= '0;
      mrem_r  <= '0;
      latch_r <= '0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      word_r  <= word_nxt;
      skip_r  <= skip_nxt;
      mrem_r  <= mrem_nxt;
      latch_r <= latch_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

### design/mss_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mss_out_buf
// Result register with a skid stage; input stall comes from the skid alone.
// ----------------------------------------------------------------------------
module mss_out_buf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               res_valid,
  input  wire mss_pkg::out_item_t res,
  output logic                    full,
  output logic                    out_valid,
  output mss_pkg::out_item_t      out_data,
  input  wire logic               out_stall
);

  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  mss_pkg::out_item_t out_data_r, out_data_nxt;
  mss_pkg::out_item_t skid_data_r, skid_data_nxt;
  logic               take;

  always_comb begin
    take           = out_valid_r && !out_stall;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || take) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### design/morph_section_size_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morph_section_size_scanner
// Walks the morph section one byte per request and reports status, bytes
// consumed and morph count when the scan ends.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in_      in         in_valid / in_stall    in_data  (in_item_t)
//  out_     out        out_valid / out_stall  out_data (out_item_t)
//  cfg_     in         cfg_we                 cfg_index, cfg_wdata
//
//  One request per cycle while in_stall is low; its result, if any, is
//  registered in the result register, or in the skid stage behind it while
//  an earlier result waits there, so a request can still be taken; in_stall
//  rises only once the skid stage holds that second result. Synchronous
//  active-low reset returns the scan to idle and the registers to their defaults.
// ----------------------------------------------------------------------------
module morph_section_size_scanner (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire mss_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output mss_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mss_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  mss_pkg::mss_cfg_t  cfg_r, cfg_nxt;
  mss_pkg::out_item_t res;
  logic               res_valid;
  logic               full;
  logic               accept;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mss_pkg::REG_ALLOW_V21:    cfg_nxt.allow_v21_types    = cfg_wdata[0];
        mss_pkg::REG_MORPH_REF:    cfg_nxt.morph_ref_bytes    = cfg_wdata;
        mss_pkg::REG_VERTEX_REF:   cfg_nxt.vertex_ref_bytes   = cfg_wdata;
        mss_pkg::REG_BONE_REF:     cfg_nxt.bone_ref_bytes     = cfg_wdata;
        mss_pkg::REG_MATERIAL_REF: cfg_nxt.material_ref_bytes = cfg_wdata;
        mss_pkg::REG_BODY_REF:     cfg_nxt.body_ref_bytes     = cfg_wdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.allow_v21_types    <= 1'b1;
      cfg_r.morph_ref_bytes    <= mss_pkg::REF_RESET;
      cfg_r.vertex_ref_bytes   <= mss_pkg::REF_RESET;
      cfg_r.bone_ref_bytes     <= mss_pkg::REF_RESET;
      cfg_r.material_ref_bytes <= mss_pkg::REF_RESET;
      cfg_r.body_ref_bytes     <= mss_pkg::REF_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  mss_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mss_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

`ifndef SYNTH
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == mss_pkg::ST_OK ||
                   out_data.status == mss_pkg::ST_TRUNC ||
                   out_data.status == mss_pkg::ST_BAD_TYPE ||
                   out_data.status == mss_pkg::ST_NEG_LEN ||
                   out_data.status == mss_pkg::ST_V21_TYPE))
    else $error("result status out of range");

  a_consumed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.consumed_bytes != '0)
    else $error("result reports zero bytes consumed");

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid ##1 out_valid) |-> $past(accept))
    else $error("result appeared without a request");
`endif

endmodule
`default_nettype wire

### dv/morph_scan_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morph_scan_tb_pkg
// Morph kinds and element sizes shared by the scanner stimulus and checker.
// ----------------------------------------------------------------------------
package morph_scan_tb_pkg;

  typedef enum logic [7:0] {
    MK_GROUP    = 8'd0,
    MK_VERTEX   = 8'd1,
    MK_BONE     = 8'd2,
    MK_UV       = 8'd3,
    MK_UVA1     = 8'd4,
    MK_UVA2     = 8'd5,
    MK_UVA3     = 8'd6,
    MK_UVA4     = 8'd7,
    MK_MATERIAL = 8'd8,
    MK_FLIP     = 8'd9,
    MK_IMPULSE  = 8'd10
  } morph_kind_e;

  // bytes per element; zero when the kind is unknown or not allowed
  function automatic logic [39:0] morph_elem_bytes(input logic [7:0] kind,
                                                   input mss_pkg::mss_cfg_t c);
    logic [39:0] sz;
    case (kind)
      MK_GROUP: sz = 40'(c.morph_ref_bytes) + 40'(mss_pkg::SZ_GROUP_BODY);
      MK_VERTEX: sz = 40'(c.vertex_ref_bytes) + 40'(mss_pkg::SZ_VERTEX_BODY);
      MK_BONE: sz = 40'(c.bone_ref_bytes) + 40'(mss_pkg::SZ_BONE_BODY);
      MK_UV, MK_UVA1, MK_UVA2, MK_UVA3, MK_UVA4: begin
        sz = 40'(c.vertex_ref_bytes) + 40'(mss_pkg::SZ_UV_BODY);
      end
      MK_MATERIAL: begin
        sz = 40'(c.material_ref_bytes) + 40'(mss_pkg::SZ_MATERIAL_BODY);
      end
      MK_FLIP: begin
        sz = c.allow_v21_types ?
             40'(c.morph_ref_bytes) + 40'(mss_pkg::SZ_FLIP_BODY) : '0;
      end
      MK_IMPULSE: begin
        sz = c.allow_v21_types ?
             40'(c.body_ref_bytes) + 40'(mss_pkg::SZ_IMPULSE_BODY) : '0;
      end
      default: sz = '0;
    endcase
    return sz;
  endfunction

endpackage

### dv/morph_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morph_scan_checker
// Follows every accepted request and register write, works out the scan
// result each request should give and compares it with the result channel.
// ----------------------------------------------------------------------------
module morph_scan_checker
  import mss_pkg::*;
  import morph_scan_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    expected_pending
);

  typedef enum logic [3:0] {
    SCAN_IDLE,
    SCAN_COUNT,
    SCAN_NAME1_LEN,
    SCAN_NAME1_BODY,
    SCAN_NAME2_LEN,
    SCAN_NAME2_BODY,
    SCAN_CATEGORY,
    SCAN_KIND,
    SCAN_ELEM_COUNT,
    SCAN_SKIP,
    SCAN_DONE
  } scan_phase_e;

  scan_phase_e phase;
  logic [1:0]  fld_idx;
  logic [31:0] word;
  logic [39:0] skip_left;
  logic [39:0] pos;
  logic [30:0] morphs_left;
  logic [30:0] morph_count;
  mss_cfg_t    cfg_copy;
  out_item_t   expected_q[$];
  out_item_t   want;
  out_item_t   res;

  initial begin
    mismatch_count   = 0;
    expected_pending = 0;
  end

  // little-endian word assembly; true once the fourth byte is in
  function automatic bit take_word_byte(input logic [7:0] b);
    if (fld_idx == 2'd0) begin
      word = '0;
    end
    word[8*fld_idx +: 8] = b;
    if (fld_idx == 2'd3) begin
      fld_idx = 2'd0;
      return 1'b1;
    end
    fld_idx = fld_idx + 2'd1;
    return 1'b0;
  endfunction

  function automatic bit close_morph();
    if (morphs_left != '0) begin
      morphs_left = morphs_left - 31'd1;
    end
    if (morphs_left == '0) begin
      return 1'b1;
    end
    phase   = SCAN_NAME1_LEN;
    fld_idx = 2'd0;
    return 1'b0;
  endfunction

  function automatic bit scan_byte(input in_item_t req, output out_item_t result);
    bit          done;
    logic [2:0]  err;
    logic [2:0]  st;
    logic [63:0] total;
    done   = 1'b0;
    err    = ST_OK;
    result = '0;
    if (req.first_byte) begin
      phase       = SCAN_COUNT;
      fld_idx     = 2'd0;
      word        = '0;
      skip_left   = '0;
      morphs_left = '0;
      morph_count = '0;
      pos         = '0;
    end
    if (phase == SCAN_IDLE || phase == SCAN_DONE) begin
      return 1'b0;
    end
    if (pos != '1) begin
      pos = pos + 40'd1;
    end
    case (phase)
      SCAN_COUNT: begin
        if (take_word_byte(req.data_byte)) begin
          // a negative count reads as no morphs
          morph_count = word[31] ? '0 : word[30:0];
          morphs_left = morph_count;
          if (morph_count == '0) begin
            done = 1'b1;
          end else begin
            phase = SCAN_NAME1_LEN;
          end
        end
      end
      SCAN_NAME1_LEN, SCAN_NAME2_LEN: begin
        if (take_word_byte(req.data_byte)) begin
          if (word[31]) begin
            err = ST_NEG_LEN;
          end else if (word == '0) begin
            phase = (phase == SCAN_NAME1_LEN) ? SCAN_NAME2_LEN : SCAN_CATEGORY;
          end else begin
            skip_left = 40'(word);
            phase = (phase == SCAN_NAME1_LEN) ? SCAN_NAME1_BODY : SCAN_NAME2_BODY;
          end
        end
      end
      SCAN_NAME1_BODY, SCAN_NAME2_BODY: begin
        if (skip_left != '0) begin
          skip_left = skip_left - 40'd1;
        end
        if (skip_left == '0) begin
          phase = (phase == SCAN_NAME1_BODY) ? SCAN_NAME2_LEN : SCAN_CATEGORY;
        end
      end
      SCAN_CATEGORY: phase = SCAN_KIND;
      SCAN_KIND: begin
        skip_left = morph_elem_bytes(req.data_byte, cfg_copy);
        if (skip_left == '0) begin
          err = (req.data_byte > MK_IMPULSE) ? ST_BAD_TYPE : ST_V21_TYPE;
        end else begin
          phase   = SCAN_ELEM_COUNT;
          fld_idx = 2'd0;
        end
      end
      SCAN_ELEM_COUNT: begin
        if (take_word_byte(req.data_byte)) begin
          total = word[31] ? '0 : 64'(word) * 64'(skip_left);
          if (total[39:0] == '0) begin
            skip_left = '0;
            done      = close_morph();
          end else begin
            skip_left = total[39:0];
            phase     = SCAN_SKIP;
          end
        end
      end
      SCAN_SKIP: begin
        if (skip_left != '0) begin
          skip_left = skip_left - 40'd1;
        end
        if (skip_left == '0) begin
          done = close_morph();
        end
      end
      default: ;
    endcase
    if (done) begin
      st = ST_OK;
    end else if (err != ST_OK) begin
      st = err;
    end else if (req.last_byte) begin
      st = ST_TRUNC;
    end else begin
      return 1'b0;
    end
    phase  = SCAN_DONE;
    result = '{status: st, consumed_bytes: pos, morph_total: morph_count};
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_copy.allow_v21_types    = 1'b1;
      cfg_copy.morph_ref_bytes    = REF_RESET;
      cfg_copy.vertex_ref_bytes   = REF_RESET;
      cfg_copy.bone_ref_bytes     = REF_RESET;
      cfg_copy.material_ref_bytes = REF_RESET;
      cfg_copy.body_ref_bytes     = REF_RESET;
      phase            = SCAN_IDLE;
      fld_idx          = '0;
      word             = '0;
      skip_left        = '0;
      morphs_left      = '0;
      morph_count      = '0;
      pos              = '0;
      expected_q.delete();
      expected_pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t morph_scan_checker: result with none expected: %s",
                   $time, "status / consumed / morphs");
          $display("%0t morph_scan_checker:   got %0d / %0d / %0d",
                   $time, out_data.status, out_data.consumed_bytes, out_data.morph_total);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_data !== want) begin
            if (out_data.status !== want.status) begin
              $display("%0t morph_scan_checker: status expected %0d, got %0d",
                       $time, want.status, out_data.status);
            end
            if (out_data.consumed_bytes !== want.consumed_bytes) begin
              $display("%0t morph_scan_checker: consumed_bytes expected %0d, got %0d",
                       $time, want.consumed_bytes, out_data.consumed_bytes);
            end
            if (out_data.morph_total !== want.morph_total) begin
              $display("%0t morph_scan_checker: morph_total expected %0d, got %0d",
                       $time, want.morph_total, out_data.morph_total);
            end
            mismatch_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ALLOW_V21:    cfg_copy.allow_v21_types    = cfg_wdata[0];
          REG_MORPH_REF:    cfg_copy.morph_ref_bytes    = cfg_wdata;
          REG_VERTEX_REF:   cfg_copy.vertex_ref_bytes   = cfg_wdata;
          REG_BONE_REF:     cfg_copy.bone_ref_bytes     = cfg_wdata;
          REG_MATERIAL_REF: cfg_copy.material_ref_bytes = cfg_wdata;
          REG_BODY_REF:     cfg_copy.body_ref_bytes     = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (scan_byte(in_data, res)) begin
          expected_q.push_back(res);
        end
      end
      expected_pending = expected_q.size();
    end
  end

endmodule

### dv/morph_section_size_scanner_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morph_section_size_scanner_tb
// Feeds the scanner directed corner sections, then random morph sections
// (mostly well formed, some truncated, broken or noisy) under a series of
// register settings, with random gaps and stalls on both channels. A
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module morph_section_size_scanner_tb;
  import mss_pkg::*;
  import morph_scan_tb_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 550;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    expected_pending;

  mss_cfg_t   tb_cfg;
  logic [7:0] sect_q[$];
  bit         calm;
  int         sent_total;
  int         idle_cycles;

  morph_section_size_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  morph_scan_checker u_scan_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .expected_pending (expected_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(16, 0);
  endfunction

  task automatic push_request(input logic [7:0] b, input bit f, input bit l);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, first_byte: f, last_byte: l};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_total++;
  endtask

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      sect_q.push_back(w[8*i +: 8]);
    end
  endfunction

  task automatic send_bytes(input int n, input bit last_on_end);
    for (int i = 0; i < n; i++) begin
      push_request(sect_q[i], i == 0, last_on_end && i == n - 1);
    end
  endtask

  // hold off until every result is in, then give the block time to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  function automatic mss_cfg_t uniform_cfg(input bit allow, input logic [2:0] w);
    mss_cfg_t c;
    c.allow_v21_types    = allow;
    c.morph_ref_bytes    = w;
    c.vertex_ref_bytes   = w;
    c.bone_ref_bytes     = w;
    c.material_ref_bytes = w;
    c.body_ref_bytes     = w;
    return c;
  endfunction

  function automatic logic [2:0] pick_ref_width();
    case ($urandom_range(3, 0))
      0: return 3'd1;
      1: return 3'd2;
      2: return 3'd4;
      default: return 3'($urandom_range(7, 0));
    endcase
  endfunction

  task automatic load_config(input int p);
    mss_cfg_t c;
    case (p)
      0: c = uniform_cfg(1'b0, 3'd0);
      1: c = uniform_cfg(1'b1, 3'd7);
      2: c = uniform_cfg(1'b0, 3'd1);
      3: c = uniform_cfg(1'b1, 3'd2);
      4: c = uniform_cfg(1'b0, 3'd4);
      default: begin
        c.allow_v21_types    = 1'($urandom_range(1, 0));
        c.morph_ref_bytes    = pick_ref_width();
        c.vertex_ref_bytes   = pick_ref_width();
        c.bone_ref_bytes     = pick_ref_width();
        c.material_ref_bytes = pick_ref_width();
        c.body_ref_bytes     = pick_ref_width();
      end
    endcase
    reg_write(REG_ALLOW_V21, 3'(c.allow_v21_types));
    reg_write(REG_MORPH_REF, c.morph_ref_bytes);
    reg_write(REG_VERTEX_REF, c.vertex_ref_bytes);
    reg_write(REG_BONE_REF, c.bone_ref_bytes);
    reg_write(REG_MATERIAL_REF, c.material_ref_bytes);
    reg_write(REG_BODY_REF, c.body_ref_bytes);
    cfg_we <= 1'b0;
    tb_cfg = c;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(5, 1)) begin
      push_request(8'($urandom_range(255, 0)), $urandom_range(3, 0) == 0,
                   $urandom_range(3, 0) == 0);
    end
  endtask

  // one morph section; open_end marks a section that cannot finish by itself
  task automatic send_section();
    int          r;
    int          n_morph;
    int          cut;
    logic [31:0] w;
    logic [7:0]  kind;
    logic [39:0] esz;
    bit          stopped;
    bit          open_end;
    sect_q.delete();
    stopped  = 1'b0;
    open_end = 1'b0;
    r = $urandom_range(99, 0);
    if (r < 80) begin
      w = $urandom_range(3, 1);
    end else if (r < 87) begin
      w = '0;
    end else if (r < 94) begin
      w = 32'h8000_0000 | $urandom;
    end else begin
      w = $urandom_range(32'h7FFF_FFFF, 4);
    end
    put_word(w);
    n_morph = w[31] ? 0 : ((w > 3) ? 3 : int'(w));
    if (!w[31] && w > 3) begin
      open_end = 1'b1;
    end
    for (int m = 0; m < n_morph && !stopped; m++) begin
      for (int s = 0; s < 2 && !stopped; s++) begin
        r = $urandom_range(99, 0);
        if (r < 85) begin
          w = $urandom_range(6, 0);
        end else if (r < 93) begin
          w = '0;
        end else if (r < 97) begin
          w = 32'h8000_0000 | $urandom;
        end else begin
          w = $urandom_range(32'h7FFF_FFFF, 64);
        end
        put_word(w);
        if (w[31]) begin
          stopped = 1'b1;
        end else begin
          if (w > 8) begin
            open_end = 1'b1;
            stopped  = 1'b1;
          end
          repeat ((w > 8) ? 8 : int'(w)) sect_q.push_back(8'($urandom_range(255, 0)));
        end
      end
      if (!stopped) begin
        sect_q.push_back(8'($urandom_range(255, 0)));
        kind = ($urandom_range(99, 0) < 92) ? 8'($urandom_range(MK_IMPULSE, MK_GROUP))
                                            : 8'($urandom_range(255, 11));
        sect_q.push_back(kind);
        esz = morph_elem_bytes(kind, tb_cfg);
        if (esz == '0) begin
          stopped = 1'b1;
        end else begin
          r = $urandom_range(99, 0);
          if (r < 60) begin
            w = 32'd1;
          end else if (r < 75) begin
            w = '0;
          end else if (r < 85) begin
            w = 32'h8000_0000 | $urandom;
          end else if (r < 93) begin
            w = 32'd2;
          end else begin
            w = $urandom_range(32'h7FFF_FFFF, 3);
          end
          put_word(w);
          if (!w[31] && w > 2) begin
            open_end = 1'b1;
            stopped  = 1'b1;
            repeat (6) sect_q.push_back(8'($urandom_range(255, 0)));
          end else if (!w[31]) begin
            repeat (int'(w) * int'(esz)) sect_q.push_back(8'($urandom_range(255, 0)));
          end
        end
      end
    end
    r = $urandom_range(99, 0);
    if (open_end || r < 20) begin
      // cut short; now and then left hanging for the next start to drop
      cut = open_end ? $urandom_range(sect_q.size(), 1)
                     : $urandom_range(sect_q.size() - 1, 1);
      send_bytes(cut, $urandom_range(9, 0) < 7);
    end else begin
      send_bytes(sect_q.size(), 1'($urandom_range(1, 0)));
      if ($urandom_range(3, 0) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          push_request(8'($urandom_range(255, 0)), 1'b0, 1'($urandom_range(1, 0)));
        end
      end
    end
  endtask

  // nothing accepted on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("morph_section_size_scanner_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int base;
    int phase_start;
    int p;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    calm        = 1'b0;
    sent_total  = 0;
    idle_cycles = 0;
    tb_cfg      = uniform_cfg(1'b1, REF_RESET);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bytes before any start are ignored
    push_request(8'hA5, 1'b0, 1'b0);
    push_request(8'h5A, 1'b0, 1'b1);
    // header dropped part way by a fresh start
    push_request(8'hFF, 1'b1, 1'b0);
    push_request(8'h00, 1'b0, 1'b0);
    // zero count, last flag on the completing byte
    sect_q.delete();
    put_word(32'd0);
    send_bytes(4, 1'b1);
    // negative count, then a stray byte after the end
    sect_q.delete();
    put_word(32'hFFFF_FFFF);
    send_bytes(4, 1'b0);
    push_request(8'h77, 1'b0, 1'b1);
    // data ends on the very first byte
    push_request(8'h00, 1'b1, 1'b1);
    // negative name length
    sect_q.delete();
    put_word(32'd1);
    put_word(32'h8000_0000);
    send_bytes(8, 1'b0);

    base = sent_total;
    p    = 0;
    while (sent_total - base < RANDOM_ITEMS) begin
      settle();
      load_config(p);
      calm        = (p % 3 == 2);
      phase_start = sent_total;
      while (sent_total - phase_start < 80) begin
        if ($urandom_range(9, 0) == 0) begin
          send_noise();
        end else begin
          send_section();
        end
      end
      // park the scanner before the registers change
      push_request(8'h00, 1'b1, 1'b1);
      p++;
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("morph_section_size_scanner_tb: done, clean");
    end else begin
      $display("morph_section_size_scanner_tb: done, errors");
    end
    $finish;
  end

endmodule
